// ===== rtl/tdg_pkg.sv =====
// ----------------------------------------------------------------------------
// tdg_pkg: shared types and constants of the thermal dvfs governor
// holds the operating point table, register map and configuration struct
// ----------------------------------------------------------------------------
package tdg_pkg;

  // default sizes
  localparam int ZONES_DEF  = 4;
  localparam int POINTS_DEF = 5;
  localparam int TABLE_ROWS = 5;

  // field widths
  localparam int FREQ_W  = 12;
  localparam int VOLT_W  = 11;
  localparam int PWR_W   = 11;
  localparam int PIDX_W  = 3;
  localparam int TEMP_W  = 19;
  localparam int HOT_W   = 18;
  localparam int CNT_W   = 32;
  localparam int CMP_W   = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // register indexes
  localparam logic [2:0] REG_MAX_FREQ = 3'd0;
  localparam logic [2:0] REG_MIN_FREQ = 3'd1;
  localparam logic [2:0] REG_TARGET   = 3'd2;
  localparam logic [2:0] REG_THR_EN   = 3'd3;
  localparam logic [2:0] REG_VSCALE   = 3'd4;

  // register reset values
  localparam logic [FREQ_W-1:0]        MAX_FREQ_RST = 12'd1800;
  localparam logic [FREQ_W-1:0]        MIN_FREQ_RST = 12'd800;
  localparam logic signed [TEMP_W-1:0] TARGET_RST   = 19'sd75000;

  // operating point table, row 0 fastest
  localparam logic [FREQ_W-1:0] TBL_FREQ [TABLE_ROWS] =
    '{12'd2400, 12'd1800, 12'd1200, 12'd800, 12'd400};
  localparam logic [VOLT_W-1:0] TBL_VOLT [TABLE_ROWS] =
    '{11'd1100, 11'd1000, 11'd900, 11'd800, 11'd700};
  localparam logic signed [CMP_W-1:0] TBL_TMAX [TABLE_ROWS] =
    '{20'sd85000, 20'sd80000, 20'sd75000, 20'sd70000, 20'sd65000};
  localparam logic [PWR_W-1:0] TBL_PWR [TABLE_ROWS] =
    '{11'd1320, 11'd900, 11'd540, 11'd320, 11'd140};

  // configuration seen by the sequencer
  typedef struct packed {
    logic [FREQ_W-1:0]        max_freq;
    logic [FREQ_W-1:0]        min_freq;
    logic signed [TEMP_W-1:0] target;
    logic                     thr_en;
    logic                     vscale_en;
  } tdg_cfg_t;

endpackage

// ===== rtl/tdg_regs.sv =====
// ----------------------------------------------------------------------------
// tdg_regs: configuration registers
// apb-style write and read access to the five governor registers
// ----------------------------------------------------------------------------
module tdg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [tdg_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [tdg_pkg::DATA_W-1:0]  pwdata_i,
  output logic [tdg_pkg::DATA_W-1:0]  prdata_o,
  output logic                        pready_o,
  output tdg_pkg::tdg_cfg_t           cfg_o
);
  import tdg_pkg::*;

  tdg_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx  = paddr_i[ADDR_W-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MAX_FREQ: cfg_d.max_freq  = pwdata_i[FREQ_W-1:0];
        REG_MIN_FREQ: cfg_d.min_freq  = pwdata_i[FREQ_W-1:0];
        REG_TARGET:   cfg_d.target    = $signed(pwdata_i[TEMP_W-1:0]);
        REG_THR_EN:   cfg_d.thr_en    = pwdata_i[0];
        REG_VSCALE:   cfg_d.vscale_en = pwdata_i[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_freq  <= MAX_FREQ_RST;
      cfg_q.min_freq  <= MIN_FREQ_RST;
      cfg_q.target    <= TARGET_RST;
      cfg_q.thr_en    <= 1'b1;
      cfg_q.vscale_en <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_MAX_FREQ: prdata_o = {{(DATA_W-FREQ_W){1'b0}}, cfg_q.max_freq};
      REG_MIN_FREQ: prdata_o = {{(DATA_W-FREQ_W){1'b0}}, cfg_q.min_freq};
      REG_TARGET:   prdata_o = {{(DATA_W-TEMP_W){cfg_q.target[TEMP_W-1]}}, cfg_q.target};
      REG_THR_EN:   prdata_o = {{(DATA_W-1){1'b0}}, cfg_q.thr_en};
      REG_VSCALE:   prdata_o = {{(DATA_W-1){1'b0}}, cfg_q.vscale_en};
      default:      prdata_o = '0;
    endcase
  end

endmodule

// ===== rtl/thermal_dvfs_governor.sv =====
// ----------------------------------------------------------------------------
// thermal_dvfs_governor: zone temperature tracking and dvfs point selection
// a sensor write lands in the zone store; a tick runs the zone scan, the throttle
// test, the point search when throttled, the target check and the lookup, one
// compare per cycle on the shared signed comparator; a stalled result slot holds
// the tick in its finish state and no new item is taken until the result is handed over.
// reset clears zone readings, operating point and event count at once and
// loads the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module thermal_dvfs_governor #(
  parameter int ZONES  = tdg_pkg::ZONES_DEF,
  parameter int POINTS = tdg_pkg::POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // apb configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tdg_pkg::ADDR_W-1:0]         paddr,
  input  logic [tdg_pkg::DATA_W-1:0]         pwdata,
  output logic [tdg_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [1:0]                         zone_i,
  input  logic signed [tdg_pkg::TEMP_W-1:0]  temp_i,
  input  logic                               valid_req_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tdg_pkg::FREQ_W-1:0]         cur_freq_o,
  output logic [tdg_pkg::VOLT_W-1:0]         cur_volt_o,
  output logic [tdg_pkg::PWR_W-1:0]          cur_power_o,
  output logic [tdg_pkg::PIDX_W-1:0]         point_index_o,
  output logic                               throttled_o,
  output logic [tdg_pkg::HOT_W-1:0]          hottest_temp_o,
  output logic [tdg_pkg::CNT_W-1:0]          throttle_count_o
);
  import tdg_pkg::*;

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int CW = (ZW > PIDX_W) ? ZW : PIDX_W;
  localparam int NP = (POINTS < TABLE_ROWS) ? POINTS : TABLE_ROWS;
  localparam logic [CW-1:0] ZONE_LAST  = CW'(ZONES - 1);
  localparam logic [CW-1:0] POINT_LAST = CW'(NP - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_THR   = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_MATCH = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  tdg_cfg_t cfg;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [HOT_W-1:0]  hot_q, hot_d;
  logic [FREQ_W-1:0] tgt_q, tgt_d;
  logic              thr_q, thr_d;

  logic [HOT_W-1:0]  zone_temp_q [ZONES];
  logic [ZONES-1:0]  zone_valid_q;

  logic [FREQ_W-1:0] cur_freq_q, cur_freq_d;
  logic [VOLT_W-1:0] cur_volt_q, cur_volt_d;
  logic [PWR_W-1:0]  cur_pwr_q, cur_pwr_d;
  logic [PIDX_W-1:0] cur_pt_q, cur_pt_d;
  logic [CNT_W-1:0]  events_q, events_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic              in_xfer;

  logic signed [CMP_W-1:0] cmp_a, cmp_b;
  logic                    cmp_gt, cmp_eq;
  logic [ZW-1:0]           zidx;
  logic [PIDX_W-1:0]       pidx;

  tdg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign zidx       = cnt_q[ZW-1:0];
  assign pidx       = cnt_q[PIDX_W-1:0];

  // sensor writes land in the zone store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_valid_q <= '0;
      for (int z = 0; z < ZONES; z++) begin
        zone_temp_q[z] <= '0;
      end
    end else if (in_xfer && !action_i) begin
      for (int z = 0; z < ZONES; z++) begin
        if (32'(zone_i) == z) begin
          zone_temp_q[z]  <= temp_i[TEMP_W-1] ? '0 : temp_i[HOT_W-1:0];
          zone_valid_q[z] <= valid_req_i;
        end
      end
    end
  end

  // operand select for the shared comparator
  always_comb begin
    case (state_q)
      S_SCAN: begin
        cmp_a = $signed({2'b00, zone_temp_q[zidx]});
        cmp_b = $signed({2'b00, hot_q});
      end
      S_THR: begin
        cmp_a = $signed({2'b00, hot_q});
        cmp_b = $signed({cfg.target[TEMP_W-1], cfg.target});
      end
      S_SRCH: begin
        cmp_a = $signed({2'b00, hot_q});
        cmp_b = TBL_TMAX[pidx];
      end
      S_CHK: begin
        cmp_a = $signed({{(CMP_W-FREQ_W){1'b0}}, tgt_q});
        cmp_b = $signed({{(CMP_W-FREQ_W){1'b0}}, cur_freq_q});
      end
      S_MATCH: begin
        cmp_a = $signed({{(CMP_W-FREQ_W){1'b0}}, tgt_q});
        cmp_b = $signed({{(CMP_W-FREQ_W){1'b0}}, TBL_FREQ[pidx]});
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hot_d       = hot_q;
    tgt_d       = tgt_q;
    thr_d       = thr_q;
    cur_freq_d  = cur_freq_q;
    cur_volt_d  = cur_volt_q;
    cur_pwr_d   = cur_pwr_q;
    cur_pt_d    = cur_pt_q;
    events_d    = events_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && action_i) begin
          hot_d   = '0;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      // one zone per cycle, keep the hottest valid reading
      S_SCAN: begin
        if (zone_valid_q[zidx] && cmp_gt) begin
          hot_d = zone_temp_q[zidx];
        end
        if (cnt_q == ZONE_LAST) begin
          state_d = S_THR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_THR: begin
        thr_d = cfg.thr_en & cmp_gt;
        if (cfg.thr_en && cmp_gt) begin
          events_d = events_q + 1'b1;
          cnt_d    = POINT_LAST;
          state_d  = S_SRCH;
        end else begin
          tgt_d   = cfg.max_freq;
          state_d = S_CHK;
        end
      end
      // slowest point upward, first one that fits
      S_SRCH: begin
        if (!cmp_gt && (TBL_FREQ[pidx] <= cfg.max_freq)) begin
          tgt_d   = TBL_FREQ[pidx];
          state_d = S_CHK;
        end else if (cnt_q == '0) begin
          tgt_d   = cfg.min_freq;
          state_d = S_CHK;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_CHK: begin
        cnt_d   = '0;
        state_d = cmp_eq ? S_FIN : S_MATCH;
      end
      // look the target up from the fastest point
      S_MATCH: begin
        if (cmp_eq) begin
          cur_freq_d = TBL_FREQ[pidx];
          cur_pwr_d  = TBL_PWR[pidx];
          cur_pt_d   = pidx;
          if (cfg.vscale_en) begin
            cur_volt_d = TBL_VOLT[pidx];
          end
          state_d = S_FIN;
        end else if (cnt_q == POINT_LAST) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      // hand the result over once the output slot is free
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      cur_freq_q  <= '0;
      cur_volt_q  <= '0;
      cur_pwr_q   <= '0;
      cur_pt_q    <= '0;
      events_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      cur_freq_q  <= cur_freq_d;
      cur_volt_q  <= cur_volt_d;
      cur_pwr_q   <= cur_pwr_d;
      cur_pt_q    <= cur_pt_d;
      events_q    <= events_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    hot_q <= hot_d;
    tgt_q <= tgt_d;
    thr_q <= thr_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cur_freq_o       <= cur_freq_q;
      cur_volt_o       <= cur_volt_q;
      cur_power_o      <= cur_pwr_q;
      point_index_o    <= cur_pt_q;
      throttled_o      <= thr_q;
      hottest_temp_o   <= hot_q;
      throttle_count_o <= events_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tdg_checker.sv =====
// ----------------------------------------------------------------------------
// tdg_checker: port level checks of the governor
// watches the channels and the reported operating point
// ----------------------------------------------------------------------------
module tdg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        action_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tdg_pkg::FREQ_W-1:0]  cur_freq_o,
  input logic [tdg_pkg::VOLT_W-1:0]  cur_volt_o,
  input logic [tdg_pkg::PIDX_W-1:0]  point_index_o,
  input logic [tdg_pkg::CNT_W-1:0]   throttle_count_o
);
  import tdg_pkg::*;

  // a pending result stays valid and its event count holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(throttle_count_o))
    else $error("pending result changed before transfer");

  // a tick keeps the block busy in the following cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i |=> !in_ready_o)
    else $error("input taken right after a tick");

  // no frequency means no point has been applied
  a_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cur_freq_o == '0) |-> (point_index_o == '0) && (cur_volt_o == '0))
    else $error("operating point set without a frequency");

  // reported point lies inside the table
  a_point_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(point_index_o) < TABLE_ROWS))
    else $error("point index outside the table");

endmodule

bind thermal_dvfs_governor tdg_checker u_tdg_checker (.*);
